[rtl/core/rm2q_pkg.sv]
package rm2q_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DATA_W    = 16;
	localparam int W_W       = 15;

	localparam int ONE     = 1 << FRAC_BITS;
	localparam int MAG_CAP = 32767;
	localparam int LIM     = (ONE < MAG_CAP) ? ONE : MAG_CAP;

	localparam int SUM_W  = ((FRAC_BITS + 2 > DATA_W + 2) ? FRAC_BITS + 2 : DATA_W + 2) + 1;
	localparam int RAD_W  = SUM_W - 1 + FRAC_BITS;
	localparam int ROOT_W = (RAD_W + 1) / 2;
	localparam int RAD2_W = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;

	localparam int SPS    = 2;
	localparam int NSQ    = (ROOT_W + SPS - 1) / SPS;
	localparam int LANES  = 4;
	localparam int SIGNS  = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [W_W-1:0]           wpart_t;

endpackage

[rtl/core/rm2q_if.sv]
interface rm2q_mat_if;
	import rm2q_pkg::*;

	logic  valid;
	logic  ready;
	data_t m00;
	data_t m01;
	data_t m02;
	data_t m10;
	data_t m11;
	data_t m12;
	data_t m20;
	data_t m21;
	data_t m22;

	modport source (
		output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input  ready
	);
	modport sink (
		input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready
	);
endinterface

interface rm2q_quat_if;
	import rm2q_pkg::*;

	logic   valid;
	logic   ready;
	wpart_t quat_w;
	data_t  quat_x;
	data_t  quat_y;
	data_t  quat_z;

	modport source (
		output valid, quat_w, quat_x, quat_y, quat_z,
		input  ready
	);
	modport sink (
		input  valid, quat_w, quat_x, quat_y, quat_z,
		output ready
	);
endinterface

[rtl/core/rotation_matrix_to_quaternion.sv]
// Rotation matrix (Q1.14) to unit quaternion (Q1.14), fully pipelined.
// An item passes stage 1, then root stages that each resolve two root bits in all four lanes,
// then the output register. Throughput: one matrix per cycle while the output is not stalled.
// A stalled output holds each full stage with only full stages after it; empty stages keep filling.
// Reset (arst_n low) clears all valid bits at once; payload registers are not reset.
module rotation_matrix_to_quaternion (
	input  logic        clk,
	input  logic        arst_n,
	rm2q_mat_if.sink    mat,
	rm2q_quat_if.source quat
);
	import rm2q_pkg::*;

	localparam logic signed [SUM_W-1:0]  ONE_S   = SUM_W'(ONE);
	localparam logic [ROOT_W-1:0]        LIM_R   = ROOT_W'(LIM);
	localparam logic signed [DATA_W-1:0] LIM_S   = DATA_W'(LIM);
	localparam logic signed [DATA_W-1:0] NLIM_S  = -LIM_S;

	// stage 1: clamped radicands and signs
	logic                    v_s1;
	logic [RAD2_W-1:0]       rad_s1 [LANES];
	logic [SIGNS-1:0]        neg_s1;

	// stage 2: root stages, indexed by step group
	logic [NSQ-1:0]          v_s2;
	logic [RAD2_W-1:0]       rad_s2  [NSQ][LANES];
	logic [REM_W-1:0]        rem_s2  [NSQ][LANES];
	logic [ROOT_W-1:0]       root_s2 [NSQ][LANES];
	logic [SIGNS-1:0]        neg_s2  [NSQ];

	// stage 3: output register
	logic                    v_s3;
	wpart_t                  w_s3;
	data_t                   x_s3;
	data_t                   y_s3;
	data_t                   z_s3;

	logic                    adv_s1;
	logic [NSQ-1:0]          adv_s2;
	logic                    adv_s3;

	logic [RAD2_W-1:0]       rad_d   [NSQ][LANES];
	logic [REM_W-1:0]        rem_d   [NSQ][LANES];
	logic [ROOT_W-1:0]       root_d  [NSQ][LANES];

	logic [RAD2_W-1:0]       rad_in  [LANES];
	logic [SIGNS-1:0]        neg_in;

	// advance chain, output side first
	always_comb begin
		adv_s3 = !v_s3 || quat.ready;
		adv_s2[NSQ-1] = !v_s2[NSQ-1] || adv_s3;
		for (int k = NSQ - 2; k >= 0; k--) begin
			adv_s2[k] = !v_s2[k] || adv_s2[k+1];
		end
		adv_s1 = !v_s1 || adv_s2[0];
	end

	assign mat.ready = adv_s1;

	always_comb begin
		logic signed [SUM_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
		logic signed [SUM_W-1:0] s [LANES];
		a00 = SUM_W'(mat.m00);
		a01 = SUM_W'(mat.m01);
		a02 = SUM_W'(mat.m02);
		a10 = SUM_W'(mat.m10);
		a11 = SUM_W'(mat.m11);
		a12 = SUM_W'(mat.m12);
		a20 = SUM_W'(mat.m20);
		a21 = SUM_W'(mat.m21);
		a22 = SUM_W'(mat.m22);
		s[0] = ONE_S + a00 + a11 + a22;
		s[1] = ONE_S + a00 - a11 - a22;
		s[2] = ONE_S - a00 + a11 - a22;
		s[3] = ONE_S - a00 - a11 + a22;
		for (int l = 0; l < LANES; l++) begin
			if (s[l][SUM_W-1]) begin
				rad_in[l] = '0;
			end else begin
				rad_in[l] = RAD2_W'({s[l][SUM_W-2:0], {FRAC_BITS{1'b0}}});
			end
		end
		neg_in[0] = a21 < a12;
		neg_in[1] = a02 < a20;
		neg_in[2] = a10 < a01;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && mat.valid) begin
			rad_s1 <= rad_in;
			neg_s1 <= neg_in;
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_root
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [RAD2_W-1:0] rad_p;
			logic [REM_W-1:0]  rem_p;
			logic [ROOT_W-1:0] root_p;

			if (k == 0) begin : g_first
				assign rad_p  = rad_s1[l];
				assign rem_p  = '0;
				assign root_p = '0;
			end else begin : g_next
				assign rad_p  = rad_s2[k-1][l];
				assign rem_p  = rem_s2[k-1][l];
				assign root_p = root_s2[k-1][l];
			end

			always_comb begin
				logic [RAD2_W-1:0] r;
				logic [REM_W-1:0]  m;
				logic [REM_W-1:0]  t;
				logic [ROOT_W-1:0] q;
				r = rad_p;
				m = rem_p;
				q = root_p;
				t = '0;
				for (int j = 0; j < SPS; j++) begin
					if (k * SPS + j < ROOT_W) begin
						m = {m[REM_W-3:0], r[RAD2_W-1 -: 2]};
						r = r << 2;
						t = {q, 2'b01};
						if (m >= t) begin
							m = m - t;
							q = {q[ROOT_W-2:0], 1'b1};
						end else begin
							q = {q[ROOT_W-2:0], 1'b0};
						end
					end
				end
				rad_d[k][l]  = r;
				rem_d[k][l]  = m;
				root_d[k][l] = q;
			end
		end

		logic v_p;
		logic [SIGNS-1:0] neg_p;
		if (k == 0) begin : g_vfirst
			assign v_p   = v_s1;
			assign neg_p = neg_s1;
		end else begin : g_vnext
			assign v_p   = v_s2[k-1];
			assign neg_p = neg_s2[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (adv_s2[k]) begin
				v_s2[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv_s2[k] && v_p) begin
				rad_s2[k]  <= rad_d[k];
				rem_s2[k]  <= rem_d[k];
				root_s2[k] <= root_d[k];
				neg_s2[k]  <= neg_p;
			end
		end
	end

	logic [DATA_W-1:0] mag [LANES];
	data_t             sx, sy, sz;

	always_comb begin
		logic [ROOT_W-1:0] h;
		h = '0;
		for (int l = 0; l < LANES; l++) begin
			h = root_s2[NSQ-1][l] >> 1;
			mag[l] = (h > LIM_R) ? DATA_W'(LIM) : DATA_W'(h);
		end
		sx = neg_s2[NSQ-1][0] ? -$signed(mag[1]) : $signed(mag[1]);
		sy = neg_s2[NSQ-1][1] ? -$signed(mag[2]) : $signed(mag[2]);
		sz = neg_s2[NSQ-1][2] ? -$signed(mag[3]) : $signed(mag[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2[NSQ-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2[NSQ-1]) begin
			w_s3 <= mag[0][W_W-1:0];
			x_s3 <= sx;
			y_s3 <= sy;
			z_s3 <= sz;
		end
	end

	assign quat.valid  = v_s3;
	assign quat.quat_w = w_s3;
	assign quat.quat_x = x_s3;
	assign quat.quat_y = y_s3;
	assign quat.quat_z = z_s3;

	a_w_cap: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> quat.quat_w <= W_W'(LIM))
		else $error("quat_w above one");

	a_x_cap: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> (quat.quat_x <= LIM_S && quat.quat_x >= NLIM_S))
		else $error("quat_x magnitude above one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(mat.valid && mat.ready) |=> v_s1)
		else $error("transfer in lost at stage 1");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(rad_s1[0]) && $stable(neg_s1)))
		else $error("stalled stage 1 changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2[NSQ-1] && adv_s3) |=> v_s3)
		else $error("last root stage dropped an item");

endmodule
